[rtl/bcdtod_pkg.sv]
package bcdtod_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] REG_TENTHS  = 2'd0;
  localparam logic [1:0] REG_SECONDS = 2'd1;
  localparam logic [1:0] REG_MINUTES = 2'd2;
  localparam logic [1:0] REG_HOURS   = 2'd3;

  localparam logic [7:0] SecLimit  = 8'd60;
  localparam logic [7:0] MinLimit  = 8'd60;
  localparam logic [7:0] HourLimit = 8'd24;
  localparam logic [4:0] TenthsMax = 5'd9;
  localparam int         AlarmSelBit = 7;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] reg_index;
    logic [7:0] write_data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       alarm_flag;
  } result_t;

  typedef struct packed {
    logic [7:0] digit;
    logic       carry;
  } bump_t;

  // Increment a BCD pair; nibbles are weighted 10/1 even when not valid BCD.
  function automatic bump_t bcd_bump(logic [7:0] b, logic [7:0] limit);
    logic [7:0] v;
    logic [3:0] tens;
    logic [7:0] rem;
    bump_t      r;
    v = {4'd0, b[7:4]} * 8'd10 + {4'd0, b[3:0]} + 8'd1;
    tens = 4'd0;
    for (int k = 1; k <= 5; k++) begin
      if (v >= 8'(k * 10)) tens = 4'(k);
    end
    rem = v - 8'(tens * 10);
    if (v >= limit) begin
      r.digit = 8'd0;
      r.carry = 1'b1;
    end else begin
      r.digit = {tens, rem[3:0]};
      r.carry = 1'b0;
    end
    return r;
  endfunction

endpackage

[rtl/bcdtod_in_stage.sv]
module bcdtod_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  bcdtod_pkg::item_t     item_i,
  input  logic                  take_ready_i,
  output logic                  take_o,
  output bcdtod_pkg::item_t     item_o
);

  logic              valid_q, valid_d;
  bcdtod_pkg::item_t item_q;
  logic              accept;

  assign take_o     = valid_q && take_ready_i;
  assign in_stall_o = valid_q && !take_ready_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = accept || (valid_q && !take_o);
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

endmodule

[rtl/bcdtod_core.sv]
module bcdtod_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  bcdtod_pkg::item_t     item_i,
  output bcdtod_pkg::result_t   result_o
);

  logic [3:0] tm_tenths_q, tm_tenths_d;
  logic [7:0] tm_sec_q, tm_sec_d, tm_min_q, tm_min_d, tm_hour_q, tm_hour_d;
  logic [3:0] al_tenths_q, al_tenths_d;
  logic [7:0] al_sec_q, al_sec_d, al_min_q, al_min_d, al_hour_q, al_hour_d;
  logic [3:0] lt_tenths_q, lt_tenths_d;
  logic [7:0] lt_sec_q, lt_sec_d, lt_min_q, lt_min_d, lt_hour_q, lt_hour_d;
  logic       latch_q, latch_d, sel_q, sel_d, fired_q, fired_d;

  logic [4:0]        tenths_inc;
  bcdtod_pkg::bump_t sec_b, min_b, hour_b;
  logic [7:0]        live_rd, latch_rd, rd;

  assign tenths_inc = {1'b0, tm_tenths_q} + 5'd1;
  assign sec_b  = bcdtod_pkg::bcd_bump(tm_sec_q, bcdtod_pkg::SecLimit);
  assign min_b  = bcdtod_pkg::bcd_bump(tm_min_q, bcdtod_pkg::MinLimit);
  assign hour_b = bcdtod_pkg::bcd_bump(tm_hour_q, bcdtod_pkg::HourLimit);

  always_comb begin
    case (item_i.reg_index)
      bcdtod_pkg::REG_TENTHS:  live_rd = {4'd0, tm_tenths_q};
      bcdtod_pkg::REG_SECONDS: live_rd = tm_sec_q;
      bcdtod_pkg::REG_MINUTES: live_rd = tm_min_q;
      default:                 live_rd = tm_hour_q;
    endcase
    case (item_i.reg_index)
      bcdtod_pkg::REG_TENTHS:  latch_rd = {4'd0, lt_tenths_q};
      bcdtod_pkg::REG_SECONDS: latch_rd = lt_sec_q;
      bcdtod_pkg::REG_MINUTES: latch_rd = lt_min_q;
      default:                 latch_rd = lt_hour_q;
    endcase
  end

  always_comb begin
    tm_tenths_d = tm_tenths_q;
    tm_sec_d    = tm_sec_q;
    tm_min_d    = tm_min_q;
    tm_hour_d   = tm_hour_q;
    al_tenths_d = al_tenths_q;
    al_sec_d    = al_sec_q;
    al_min_d    = al_min_q;
    al_hour_d   = al_hour_q;
    lt_tenths_d = lt_tenths_q;
    lt_sec_d    = lt_sec_q;
    lt_min_d    = lt_min_q;
    lt_hour_d   = lt_hour_q;
    latch_d     = latch_q;
    sel_d       = sel_q;
    fired_d     = fired_q;
    rd          = 8'd0;

    case (item_i.opcode)
      bcdtod_pkg::OP_TICK: begin
        if (tenths_inc > bcdtod_pkg::TenthsMax) begin
          tm_tenths_d = 4'd0;
          tm_sec_d    = sec_b.digit;
          // minutes only move on a seconds wrap, hours on both wrapping
          if (sec_b.carry) begin
            tm_min_d = min_b.digit;
            if (min_b.carry) tm_hour_d = hour_b.digit;
          end
        end else begin
          tm_tenths_d = tenths_inc[3:0];
        end
        if (tm_hour_d == al_hour_q && tm_min_d == al_min_q &&
            tm_sec_d == al_sec_q && tm_tenths_d == al_tenths_q) begin
          fired_d = 1'b1;
        end
      end
      bcdtod_pkg::OP_WRITE: begin
        case (item_i.reg_index)
          bcdtod_pkg::REG_TENTHS: begin
            sel_d = item_i.write_data[bcdtod_pkg::AlarmSelBit];
            if (sel_d) al_tenths_d = item_i.write_data[3:0];
            else       tm_tenths_d = item_i.write_data[3:0];
          end
          bcdtod_pkg::REG_SECONDS: begin
            if (sel_q) al_sec_d = item_i.write_data;
            else       tm_sec_d = item_i.write_data;
          end
          bcdtod_pkg::REG_MINUTES: begin
            if (sel_q) al_min_d = item_i.write_data;
            else       tm_min_d = item_i.write_data;
          end
          default: begin
            if (sel_q) al_hour_d = item_i.write_data;
            else       tm_hour_d = item_i.write_data;
          end
        endcase
      end
      bcdtod_pkg::OP_READ: begin
        if (latch_q) begin
          rd = latch_rd;
          if (item_i.reg_index == bcdtod_pkg::REG_TENTHS) latch_d = 1'b0;
        end else begin
          rd = live_rd;
          if (item_i.reg_index == bcdtod_pkg::REG_HOURS) begin
            lt_tenths_d = tm_tenths_q;
            lt_sec_d    = tm_sec_q;
            lt_min_d    = tm_min_q;
            lt_hour_d   = tm_hour_q;
            latch_d     = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign result_o.read_data  = rd;
  assign result_o.alarm_flag = fired_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tm_tenths_q <= '0;
      tm_sec_q    <= '0;
      tm_min_q    <= '0;
      tm_hour_q   <= '0;
      al_tenths_q <= '0;
      al_sec_q    <= '0;
      al_min_q    <= '0;
      al_hour_q   <= '0;
      lt_tenths_q <= '0;
      lt_sec_q    <= '0;
      lt_min_q    <= '0;
      lt_hour_q   <= '0;
      latch_q     <= 1'b0;
      sel_q       <= 1'b0;
      fired_q     <= 1'b0;
    end else if (fire_i) begin
      tm_tenths_q <= tm_tenths_d;
      tm_sec_q    <= tm_sec_d;
      tm_min_q    <= tm_min_d;
      tm_hour_q   <= tm_hour_d;
      al_tenths_q <= al_tenths_d;
      al_sec_q    <= al_sec_d;
      al_min_q    <= al_min_d;
      al_hour_q   <= al_hour_d;
      lt_tenths_q <= lt_tenths_d;
      lt_sec_q    <= lt_sec_d;
      lt_min_q    <= lt_min_d;
      lt_hour_q   <= lt_hour_d;
      latch_q     <= latch_d;
      sel_q       <= sel_d;
      fired_q     <= fired_d;
    end
  end

endmodule

[rtl/bcdtod_out_stage.sv]
module bcdtod_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  bcdtod_pkg::result_t   result_i,
  output logic                  ready_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bcdtod_pkg::result_t   result_o
);

  logic                valid_q, valid_d;
  bcdtod_pkg::result_t result_q;

  // room when empty or when the held transaction leaves this cycle
  assign ready_o     = !valid_q || !out_stall_i;
  assign valid_d     = fire_i || (valid_q && out_stall_i);
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      result_q <= result_i;
    end
  end

endmodule

[rtl/bcd_time_of_day_clock.sv]
// BCD time-of-day clock with alarm. Each input transaction is a tick of one tenth
// second, a register write, a register read or, for opcode 3, no operation, and
// yields exactly one result transaction carrying the read byte (0 unless a read)
// and the sticky alarm flag. Writes go to the alarm registers while bit 7 of the
// last tenths write was set. Reading hours freezes a copy of the time until tenths
// is read. A new transaction can be taken every cycle while results drain. An
// accepted input is held in the input register, and its result is registered in
// the result register. All state is updated as a transaction moves from the input
// register to the result register. A stalled result holds the input register,
// which then stalls the input.
module bcd_time_of_day_clock (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic [1:0] reg_index_i,
  input  logic [7:0] write_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       alarm_flag_o
);

  bcdtod_pkg::item_t   in_item, cur_item;
  bcdtod_pkg::result_t core_res, out_res;
  logic                fire, out_ready;

  assign in_item.opcode     = opcode_i;
  assign in_item.reg_index  = reg_index_i;
  assign in_item.write_data = write_data_i;

  bcdtod_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_i       (in_item),
    .take_ready_i (out_ready),
    .take_o       (fire),
    .item_o       (cur_item)
  );

  bcdtod_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (cur_item),
    .result_o (core_res)
  );

  bcdtod_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .result_i    (core_res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign read_data_o  = out_res.read_data;
  assign alarm_flag_o = out_res.alarm_flag;

endmodule
